### hw/rtl/ascon_pkg.sv
package ascon_pkg;

    localparam int unsigned NumRounds = 12;
    localparam int unsigned WordW     = 64;
    localparam int unsigned RcW       = 8;

    // five-word permutation state
    typedef struct packed {
        logic [WordW-1:0] w0;
        logic [WordW-1:0] w1;
        logic [WordW-1:0] w2;
        logic [WordW-1:0] w3;
        logic [WordW-1:0] w4;
    } t_state;

    // round constants, first round first
    localparam logic [RcW-1:0] RoundConst [NumRounds] = '{
        8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
        8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
    };

    // right rotation by a fixed non-zero amount
    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x,
                                              input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage

### hw/rtl/ascon_round.sv
module ascon_round (
    input  ascon_pkg::t_state                i_state,
    input  logic [ascon_pkg::RcW-1:0]        i_rc,
    output ascon_pkg::t_state                o_state
);

    logic [ascon_pkg::WordW-1:0] a, b, c, d, e;
    logic [ascon_pkg::WordW-1:0] k0, k1, k2, k3, k4;
    logic [ascon_pkg::WordW-1:0] t0, t1, t2, t3, t4;

    // constant addition and pre-xors
    always_comb begin
        a = i_state.w0 ^ i_state.w4;
        b = i_state.w1;
        c = i_state.w2 ^ {{(ascon_pkg::WordW - ascon_pkg::RcW){1'b0}}, i_rc} ^ i_state.w1;
        d = i_state.w3;
        e = i_state.w4 ^ i_state.w3;
    end

    // and-not layer
    always_comb begin
        k0 = a ^ (~b & c);
        k1 = b ^ (~c & d);
        k2 = c ^ (~d & e);
        k3 = d ^ (~e & a);
        k4 = e ^ (~a & b);
    end

    // post-xors and inversion of word 2
    always_comb begin
        t0 = k0 ^ k4;
        t1 = k1 ^ k0;
        t2 = ~k2;
        t3 = k3 ^ k2;
        t4 = k4;
    end

    // linear diffusion
    always_comb begin
        o_state.w0 = t0 ^ ascon_pkg::rotr(t0, 19) ^ ascon_pkg::rotr(t0, 28);
        o_state.w1 = t1 ^ ascon_pkg::rotr(t1, 61) ^ ascon_pkg::rotr(t1, 39);
        o_state.w2 = t2 ^ ascon_pkg::rotr(t2, 1)  ^ ascon_pkg::rotr(t2, 6);
        o_state.w3 = t3 ^ ascon_pkg::rotr(t3, 10) ^ ascon_pkg::rotr(t3, 17);
        o_state.w4 = t4 ^ ascon_pkg::rotr(t4, 7)  ^ ascon_pkg::rotr(t4, 41);
    end

endmodule

### hw/rtl/ascon_p12_permutation.sv
// Ascon p^12 permutation on a 320-bit state given as five 64-bit words. Each of
// the twelve rounds has its own register stage, so an item passes through each
// stage register in order before it leaves, and a new item can be taken every
// cycle unless the input is stalled. Each stage holds its item until the stage
// after it has room, so a stall on the output fills empty stages first and stalls
// the input only once the stage-one register is occupied and cannot move on.
module ascon_p12_permutation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_in_word0,
    input  logic [63:0] i_in_word1,
    input  logic [63:0] i_in_word2,
    input  logic [63:0] i_in_word3,
    input  logic [63:0] i_in_word4,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_word0,
    output logic [63:0] o_out_word1,
    output logic [63:0] o_out_word2,
    output logic [63:0] o_out_word3,
    output logic [63:0] o_out_word4
);

    localparam int unsigned N = ascon_pkg::NumRounds;

    ascon_pkg::t_state w_in;
    ascon_pkg::t_state w_src  [N];
    ascon_pkg::t_state n_state[N];
    ascon_pkg::t_state r_state[N];
    logic [N-1:0]      r_valid;
    logic [N-1:0]      w_src_valid;
    logic [N-1:0]      w_adv;

    assign w_in = '{w0: i_in_word0, w1: i_in_word1, w2: i_in_word2,
                    w3: i_in_word3, w4: i_in_word4};

    // stage sources: input item for the first round, previous stage otherwise
    always_comb begin
        w_src[0]       = w_in;
        w_src_valid[0] = i_valid;
        for (int k = 1; k < N; k++) begin
            w_src[k]       = r_state[k-1];
            w_src_valid[k] = r_valid[k-1];
        end
    end

    // a stage may load when it is empty or its item moves on
    always_comb begin
        w_adv[N-1] = !r_valid[N-1] || !i_stall;
        for (int k = N - 2; k >= 0; k--) begin
            w_adv[k] = !r_valid[k] || w_adv[k+1];
        end
    end

    // one round per stage
    for (genvar g = 0; g < N; g++) begin : g_round
        ascon_round u_round (
            .i_state (w_src[g]),
            .i_rc    (ascon_pkg::RoundConst[g]),
            .o_state (n_state[g])
        );
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (w_adv[k]) begin
                    r_valid[k] <= w_src_valid[k];
                end
            end
        end
    end

    // round state registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (w_adv[k]) begin
                r_state[k] <= n_state[k];
            end
        end
    end

    assign o_stall     = !w_adv[0];
    assign o_valid     = r_valid[N-1];
    assign o_out_word0 = r_state[N-1].w0;
    assign o_out_word1 = r_state[N-1].w1;
    assign o_out_word2 = r_state[N-1].w2;
    assign o_out_word3 = r_state[N-1].w3;
    assign o_out_word4 = r_state[N-1].w4;

endmodule

### hw/rtl/ascon_p12_checker.sv
module ascon_p12_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_out_word0,
    input logic [63:0] o_out_word1,
    input logic [63:0] o_out_word2,
    input logic [63:0] o_out_word3,
    input logic [63:0] o_out_word4
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item dropped while stalled");

    // a stalled result item keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_word0) && $stable(o_out_word1) &&
            $stable(o_out_word2) && $stable(o_out_word3) && $stable(o_out_word4))
        else $error("stalled result payload changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item offered after reset");

    // with a free output the input is never held off
    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    // stall only arises from a held result item
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

endmodule

bind ascon_p12_permutation ascon_p12_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_word0 (o_out_word0),
    .o_out_word1 (o_out_word1),
    .o_out_word2 (o_out_word2),
    .o_out_word3 (o_out_word3),
    .o_out_word4 (o_out_word4)
);
